// File: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// condition in a cycle implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition in a cycle implies a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/i2cmt_pkg.sv
// types, codes and constants of the i2c master transmit sequencer
`timescale 1ns / 1ps

package i2cmt_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam int TIMEOUT_W = 20;
    localparam int RETRY_W   = 4;
    localparam int IDX_W     = 9;
    localparam int CFG_W     = TIMEOUT_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd500000;
    localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd3;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_BEGIN  = 2'd1,
        FUNC_STATUS = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WSTART = 2'd1,
        PH_WADDR  = 2'd2,
        PH_SEND   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_SEND  = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BUSY       = 3'd1,
        ST_START_FAIL = 3'd2,
        ST_ADDR_NACK  = 3'd3,
        ST_ARB_LOST   = 3'd4,
        ST_DATA_NACK  = 3'd5,
        ST_TIMEOUT    = 3'd6,
        ST_UNEXPECTED = 3'd7
    } status_t;

    localparam logic [7:0] CODE_MASK      = 8'hF8;
    localparam logic [7:0] CODE_START     = 8'h08;
    localparam logic [7:0] CODE_ADDR_ACK  = 8'h18;
    localparam logic [7:0] CODE_ADDR_NACK = 8'h20;
    localparam logic [7:0] CODE_DATA_ACK  = 8'h28;
    localparam logic [7:0] CODE_DATA_NACK = 8'h30;
    localparam logic [7:0] CODE_ARB_LOST  = 8'h38;

    // decision of one word, handed to the output stage
    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic       use_ram;
        logic       done_res;
        status_t    status;
    } res_t;

endpackage

// File: design/i2c_master_transmit_sequencer.sv
// top level of the i2c master transmit sequencer
`timescale 1ns / 1ps
//
// channel   dir  tuser            tdata
// s_axis    in   func[1:0]        byte_index, data_byte, slave_address,
//                                 byte_count, status_code (40 bits)
// m_axis    out  action[1:0]      tx_byte, done_res, status (16 bits)
// cfg       in   cfg_index        cfg_wdata (20 bits), written when cfg_we
//
// one word per cycle unless the output stalls; each input word gives one result word
// in the next cycle, from the output register and the registered read of the buffer ram
// aresetn clears phase and counters and sets config to its defaults; the buffer ram has no reset
// a stalled result holds the output register and stops input for that cycle

module i2c_master_transmit_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [i2cmt_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // lsb up: byte_index[7:0], data_byte[15:8], slave_address[22:16],
    // byte_count[30:23], status_code[38:31], zero pad[39]
    input  logic [39:0]                 s_tdata,
    // func[1:0]
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // lsb up: tx_byte[7:0], done_res[8], status[11:9], zero pad[15:12]
    output logic [15:0]                 m_tdata,
    // action[1:0]
    output logic [1:0]                  m_tuser
);
    import i2cmt_pkg::*;

    logic              accept;
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [BUF_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    res_t              res;

    assign accept = s_tvalid && s_tready;

    i2cmt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .func          (s_tuser),
        .byte_index    (s_tdata[7:0]),
        .data_byte     (s_tdata[15:8]),
        .slave_address (s_tdata[22:16]),
        .byte_count    (s_tdata[30:23]),
        .status_code   (s_tdata[38:31]),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .res           (res)
    );

    i2cmt_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    i2cmt_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .res       (res),
        .ram_rdata (ram_rdata),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: design/i2cmt_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module i2cmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/i2cmt_ctrl.sv
// transfer control: phase, counters, config registers and buffer access
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cmt_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [i2cmt_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        accept,
    input  logic [1:0]                  func,
    input  logic [7:0]                  byte_index,
    input  logic [7:0]                  data_byte,
    input  logic [6:0]                  slave_address,
    input  logic [7:0]                  byte_count,
    input  logic [7:0]                  status_code,
    output logic                        ram_we,
    output logic [i2cmt_pkg::BUF_AW-1:0] ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic                        ram_re,
    output logic [i2cmt_pkg::BUF_AW-1:0] ram_raddr,
    output i2cmt_pkg::res_t             res
);
    import i2cmt_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     next_index_reg, next_index_next;
    logic [7:0]           length_reg, length_next;
    logic [6:0]           target_reg, target_next;
    logic [RETRY_W-1:0]   nack_count_reg, nack_count_next;
    logic [TIMEOUT_W-1:0] wait_count_reg, wait_count_next;
    logic [TIMEOUT_W-1:0] timeout_limit_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;

    func_t                fn;
    logic [7:0]           code;
    logic [TIMEOUT_W-1:0] wait_inc;
    logic                 timed_out;
    logic                 last_sent;
    logic                 retry_ok;
    logic [IDX_W-1:0]     prev_index;

    assign fn         = func_t'(func);
    assign code       = status_code & CODE_MASK;
    assign wait_inc   = wait_count_reg + 1'b1;
    assign timed_out  = (wait_inc == '0) || (wait_inc >= timeout_limit_reg);
    assign last_sent  = next_index_reg >= {1'b0, length_reg};
    assign retry_ok   = nack_count_reg < retry_limit_reg;
    assign prev_index = next_index_reg - 1'b1;

    assign ram_we    = accept && (fn == FUNC_LOAD);
    assign ram_waddr = byte_index[BUF_AW-1:0];
    assign ram_wdata = data_byte;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (fn)
                FUNC_LOAD: begin
                    phase_next = phase_reg;
                end
                FUNC_BEGIN: begin
                    if (phase_reg == PH_IDLE && byte_count != 8'd0) begin
                        phase_next = PH_WSTART;
                    end
                end
                FUNC_STATUS: begin
                    unique case (phase_reg)
                        PH_IDLE: phase_next = PH_IDLE;
                        PH_WSTART: begin
                            phase_next = (code == CODE_START) ? PH_WADDR : PH_IDLE;
                        end
                        PH_WADDR: begin
                            phase_next = (code == CODE_ADDR_ACK) ? PH_SEND : PH_IDLE;
                        end
                        PH_SEND: begin
                            if ((code == CODE_DATA_ACK && last_sent) ||
                                (code == CODE_DATA_NACK && !retry_ok) ||
                                code == CODE_ARB_LOST) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                FUNC_TICK: begin
                    if ((phase_reg == PH_WSTART || phase_reg == PH_WADDR) && timed_out) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // result word, counters and buffer read
    always_comb begin
        next_index_next = next_index_reg;
        length_next     = length_reg;
        target_next     = target_reg;
        nack_count_next = nack_count_reg;
        wait_count_next = wait_count_reg;
        ram_re          = 1'b0;
        ram_raddr       = next_index_reg[BUF_AW-1:0];
        res             = '{action: ACT_NONE, tx_byte: 8'd0, use_ram: 1'b0,
                            done_res: 1'b0, status: ST_OK};
        if (accept) begin
            unique case (fn)
                FUNC_LOAD: begin
                    res.done_res = 1'b0;
                end
                FUNC_BEGIN: begin
                    if (phase_reg != PH_IDLE) begin
                        res.done_res = 1'b1;
                        res.status   = ST_BUSY;
                    end else if (byte_count == 8'd0) begin
                        res.done_res = 1'b1;
                    end else begin
                        target_next     = slave_address;
                        length_next     = byte_count;
                        next_index_next = '0;
                        nack_count_next = '0;
                        wait_count_next = '0;
                        res.action      = ACT_START;
                    end
                end
                FUNC_STATUS: begin
                    unique case (phase_reg)
                        PH_IDLE: res.done_res = 1'b0;
                        PH_WSTART: begin
                            wait_count_next = '0;
                            if (code == CODE_START) begin
                                res.action  = ACT_SEND;
                                res.tx_byte = {target_reg, 1'b0};
                            end else begin
                                next_index_next = '0;
                                length_next     = '0;
                                nack_count_next = '0;
                                res.done_res    = 1'b1;
                                res.status      = ST_START_FAIL;
                            end
                        end
                        PH_WADDR: begin
                            wait_count_next = '0;
                            nack_count_next = '0;
                            if (code == CODE_ADDR_ACK) begin
                                next_index_next = IDX_W'(1);
                                ram_re          = 1'b1;
                                ram_raddr       = '0;
                                res.action      = ACT_SEND;
                                res.use_ram     = 1'b1;
                            end else begin
                                next_index_next = '0;
                                length_next     = '0;
                                res.done_res    = 1'b1;
                                priority if (code == CODE_ADDR_NACK) begin
                                    res.action = ACT_STOP;
                                    res.status = ST_ADDR_NACK;
                                end else if (code == CODE_ARB_LOST) begin
                                    res.status = ST_ARB_LOST;
                                end else begin
                                    res.action = ACT_STOP;
                                    res.status = ST_UNEXPECTED;
                                end
                            end
                        end
                        PH_SEND: begin
                            priority if (code == CODE_DATA_ACK) begin
                                nack_count_next = '0;
                                if (last_sent) begin
                                    next_index_next = '0;
                                    length_next     = '0;
                                    wait_count_next = '0;
                                    res.action      = ACT_STOP;
                                    res.done_res    = 1'b1;
                                end else begin
                                    next_index_next = next_index_reg + 1'b1;
                                    ram_re          = 1'b1;
                                    ram_raddr       = next_index_reg[BUF_AW-1:0];
                                    res.action      = ACT_SEND;
                                    res.use_ram     = 1'b1;
                                end
                            end else if (code == CODE_DATA_NACK) begin
                                if (retry_ok) begin
                                    nack_count_next = nack_count_reg + 1'b1;
                                    ram_re          = 1'b1;
                                    ram_raddr       = prev_index[BUF_AW-1:0];
                                    res.action      = ACT_SEND;
                                    res.use_ram     = 1'b1;
                                end else begin
                                    next_index_next = '0;
                                    length_next     = '0;
                                    nack_count_next = '0;
                                    wait_count_next = '0;
                                    res.action      = ACT_STOP;
                                    res.done_res    = 1'b1;
                                    res.status      = ST_DATA_NACK;
                                end
                            end else if (code == CODE_ARB_LOST) begin
                                next_index_next = '0;
                                length_next     = '0;
                                nack_count_next = '0;
                                wait_count_next = '0;
                                res.done_res    = 1'b1;
                                res.status      = ST_ARB_LOST;
                            end
                        end
                        default: res.done_res = 1'b0;
                    endcase
                end
                FUNC_TICK: begin
                    if (phase_reg == PH_WSTART || phase_reg == PH_WADDR) begin
                        if (timed_out) begin
                            next_index_next = '0;
                            length_next     = '0;
                            nack_count_next = '0;
                            wait_count_next = '0;
                            res.done_res    = 1'b1;
                            res.status      = ST_TIMEOUT;
                        end else begin
                            wait_count_next = wait_inc;
                        end
                    end
                end
                default: res.done_res = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            next_index_reg    <= '0;
            length_reg        <= '0;
            target_reg        <= '0;
            nack_count_reg    <= '0;
            wait_count_reg    <= '0;
            timeout_limit_reg <= TIMEOUT_RESET;
            retry_limit_reg   <= RETRY_RESET;
        end else begin
            phase_reg      <= phase_next;
            next_index_reg <= next_index_next;
            length_reg     <= length_next;
            target_reg     <= target_next;
            nack_count_reg <= nack_count_next;
            wait_count_reg <= wait_count_next;
            if (cfg_we) begin
                if (cfg_index == CFG_TIMEOUT) begin
                    timeout_limit_reg <= cfg_wdata[TIMEOUT_W-1:0];
                end else begin
                    retry_limit_reg <= cfg_wdata[RETRY_W-1:0];
                end
            end
        end
    end

    // counters are cleared whenever the bus is released
    `ASSERT_IMPLIES(a_idle_clear, phase_reg == PH_IDLE,
        next_index_reg == '0 && nack_count_reg == '0 && wait_count_reg == '0,
        "counters not cleared in idle")
    // a buffered byte is only sent while in the data phase
    `ASSERT_NEXT(a_ram_send_phase, res.use_ram, phase_reg == PH_SEND,
        "buffer read outside data phase")

endmodule

// File: design/i2cmt_out.sv
// output register stage: holds one result word and merges the buffer byte
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cmt_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  i2cmt_pkg::res_t res,
    input  logic [7:0]      ram_rdata,
    output logic            ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser
);
    import i2cmt_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;
    logic [7:0] byte_out;

    assign ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    // ram data only moves on a read, which only comes with a new word here
    assign byte_out = res_reg.use_ram ? ram_rdata : res_reg.tx_byte;

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.done_res, byte_out};

    `ASSERT_IMPLIES(a_ram_is_send, valid_reg && res_reg.use_ram,
        res_reg.action == ACT_SEND && !res_reg.done_res,
        "buffer byte on a word that is not a send")

endmodule
